@@ sv/sdcp_pkg.sv @@
// Shared types, character codes and helpers for the serial display command parser.
// No dependencies; every file but sdcp_line_mem imports this package.
`default_nettype none

package sdcp_pkg;

	localparam int LINE_BYTES_DEF = 32;
	localparam int PREFIX_LEN     = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Row-number reader: skip blanks, then sign or digits, then digits only.
	typedef enum logic [1:0] {
		PH_BLANK,
		PH_DIGIT,
		PH_DONE
	} parse_phase_t;

	typedef enum logic {
		EM_IDLE,
		EM_SHOW
	} emit_state_t;

	// Verdict on a finished line, valid with its newline.
	typedef struct packed {
		logic emit;
		logic row;
	} line_verdict_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = CH_L;
			2'd1: c = CH_C;
			2'd2: c = CH_D;
			default: c = CH_COLON;
		endcase
		return c;
	endfunction

	// Magnitude saturates at 2: anything above 1 is rejected anyway.
	function automatic logic [1:0] mag_step(input logic [1:0] mag, input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		if (mag != 2'd0)
			return 2'd2;
		else if (d >= 8'd2)
			return 2'd2;
		else
			return d[1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/sdcp_line_mem.sv @@
// Line store: one write port, one read port with registered read data.
// Depends on nothing beyond its parameters.
`default_nettype none

module sdcp_line_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Hold read data between reads so a stalled result stays put.
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

@@ sv/sdcp_line_scan.sv @@
// Byte intake: fill count, overflow flag and on-the-fly checks of prefix, comma and row.
// Depends on sdcp_pkg; drives the write port of sdcp_line_mem.
`default_nettype none

module sdcp_line_scan #(
	parameter int LINE_BYTES = 32,
	parameter int AW         = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    fire,
	input  wire logic [7:0]              rx_byte,
	output logic                         wr_en,
	output logic      [AW-1:0]           wr_addr,
	output logic      [7:0]              wr_data,
	output sdcp_pkg::line_verdict_t      verdict,
	output logic      [AW-1:0]           text_start,
	output logic      [AW-1:0]           text_end
);

	import sdcp_pkg::*;

	localparam logic [AW-1:0] MaxFill = AW'(LINE_BYTES - 1);
	localparam logic [AW-1:0] PreLen  = AW'(PREFIX_LEN);

	logic [AW-1:0] fill_q;
	logic          ovf_q;
	logic          zero_seen_q;
	logic [AW-1:0] zero_idx_q;
	logic          pre_bad_q;
	logic          comma_found_q;
	logic [AW-1:0] comma_idx_q;
	parse_phase_t  phase_q;
	logic          neg_q;
	logic [1:0]    mag_q;

	logic is_cr, is_lf, data_byte, store, row_ok;

	assign is_cr     = rx_byte == CH_CR;
	assign is_lf     = rx_byte == CH_LF;
	assign data_byte = fire && !is_cr && !is_lf && !ovf_q;
	assign store     = data_byte && (fill_q != MaxFill);

	assign wr_en   = store;
	assign wr_addr = fill_q;
	assign wr_data = rx_byte;

	// Text runs from just past the comma to the first zero byte or the line end.
	assign text_end   = zero_seen_q ? zero_idx_q : fill_q;
	assign text_start = comma_idx_q + AW'(1);

	assign row_ok = (mag_q == 2'd0) || ((mag_q == 2'd1) && !neg_q);

	assign verdict.emit     = fire && is_lf && !ovf_q && (text_end >= PreLen) &&
	                          !pre_bad_q && comma_found_q && row_ok;
	assign verdict.row      = mag_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			ovf_q         <= 1'b0;
			zero_seen_q   <= 1'b0;
			pre_bad_q     <= 1'b0;
			comma_found_q <= 1'b0;
			phase_q       <= PH_BLANK;
			neg_q         <= 1'b0;
			mag_q         <= 2'd0;
		end else if (fire && is_lf) begin
			fill_q        <= '0;
			ovf_q         <= 1'b0;
			zero_seen_q   <= 1'b0;
			pre_bad_q     <= 1'b0;
			comma_found_q <= 1'b0;
			phase_q       <= PH_BLANK;
			neg_q         <= 1'b0;
			mag_q         <= 2'd0;
		end else if (data_byte && (fill_q == MaxFill)) begin
			ovf_q <= 1'b1;
		end else if (store) begin
			fill_q <= fill_q + AW'(1);
			if (!zero_seen_q) begin
				if (rx_byte == CH_NUL) begin
					zero_seen_q <= 1'b1;
				end else if (fill_q < PreLen) begin
					if (rx_byte != prefix_char(fill_q[1:0]))
						pre_bad_q <= 1'b1;
				end else if (!comma_found_q) begin
					if (rx_byte == CH_COMMA) begin
						comma_found_q <= 1'b1;
					end else begin
						unique case (phase_q)
							PH_BLANK: begin
								if (is_blank(rx_byte)) begin
									phase_q <= PH_BLANK;
								end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
									neg_q   <= rx_byte == CH_MINUS;
									phase_q <= PH_DIGIT;
								end else if (is_digit(rx_byte)) begin
									mag_q   <= mag_step(mag_q, rx_byte);
									phase_q <= PH_DIGIT;
								end else begin
									phase_q <= PH_DONE;
								end
							end
							PH_DIGIT: begin
								if (is_digit(rx_byte))
									mag_q <= mag_step(mag_q, rx_byte);
								else
									phase_q <= PH_DONE;
							end
							default: phase_q <= PH_DONE;
						endcase
					end
				end
			end
		end
	end

	// Position payloads need no reset.
	always_ff @(posedge clk) begin
		if (store && !zero_seen_q && rx_byte == CH_NUL)
			zero_idx_q <= fill_q;
		if (store && !zero_seen_q && rx_byte == CH_COMMA && !comma_found_q &&
		    !(fill_q < PreLen))
			comma_idx_q <= fill_q;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MaxFill)
		else $error("fill count beyond line capacity");

	a_ovf_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> !wr_en)
		else $error("byte stored into an overflowed line");

	a_comma_after_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		comma_found_q |-> (comma_idx_q >= PreLen && comma_idx_q < fill_q))
		else $error("comma position outside the kept line");

endmodule

`default_nettype wire

@@ sv/sdcp_emit.sv @@
// Result sequencer: walks stored text via the read port, one char a cycle while not stalled.
// Depends on sdcp_pkg; reads sdcp_line_mem.
`default_nettype none

module sdcp_emit #(
	parameter int AW = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire sdcp_pkg::line_verdict_t verdict,
	input  wire logic [AW-1:0]           text_start,
	input  wire logic [AW-1:0]           text_end,
	output logic                         rd_en,
	output logic      [AW-1:0]           rd_addr,
	input  wire logic [7:0]              rd_data,
	output logic                         busy,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic                         display_row,
	output logic      [7:0]              text_char,
	output logic                         has_char,
	output logic                         last_of_run
);

	import sdcp_pkg::*;

	emit_state_t   state_q, state_nxt;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] end_q;
	logic          row_q;
	logic          has_q;
	logic          start, advance, last;

	assign start   = verdict.emit && (state_q == EM_IDLE);
	assign last    = !has_q || ({1'b0, ptr_q} + (AW+1)'(1) == {1'b0, end_q});
	assign advance = (state_q == EM_SHOW) && !out_stall && !last;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			EM_IDLE: if (verdict.emit) state_nxt = EM_SHOW;
			EM_SHOW: if (!out_stall && last) state_nxt = EM_IDLE;
			default: state_nxt = EM_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q + AW'(1);
		unique case (state_q)
			EM_IDLE: begin
				rd_en   = start;
				rd_addr = text_start;
			end
			EM_SHOW: rd_en = advance;
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= EM_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ptr_q <= text_start;
			end_q <= text_end;
			row_q <= verdict.row;
			has_q <= text_start != text_end;
		end else if (advance) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	assign busy        = state_q != EM_IDLE;
	assign out_valid   = state_q == EM_SHOW;
	assign display_row = row_q;
	assign has_char    = has_q;
	assign text_char   = has_q ? rd_data : CH_NUL;
	assign last_of_run = last;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.emit |-> state_q == EM_IDLE)
		else $error("new line verdict while a run is still going out");

	a_ptr_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_q) |-> ptr_q < end_q)
		else $error("read pointer past end of text");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run) |=> !out_valid)
		else $error("results continue after the final one");

endmodule

`default_nettype wire

@@ sv/serial_display_command_parser.sv @@
// Top level of the serial display command parser: byte intake, line store and result sequencer.
// Depends on sdcp_pkg, sdcp_line_scan, sdcp_line_mem and sdcp_emit.
`default_nettype none

// Receives serial bytes and turns lines of the form "LCD:<row>,<text>" into a run of
// characters for display row 0 or 1. Carriage returns are dropped; other bytes are kept
// in a LINE_BYTES-entry line memory, at most LINE_BYTES-1 per line, and a longer line is
// discarded through its newline. Prefix, first comma, first zero byte and the atoi-style
// row number are tracked as bytes arrive, so the newline is judged with no scan of the
// memory. Every non-newline byte is one transaction. A newline of a line that passes
// starts the run; in_stall stays high from the next cycle until the last result of the
// run has been taken. Results come one per cycle while out_stall is low, from the line
// memory's single registered read port, first result in the cycle after the newline;
// a line with k text characters gives k results, and empty text gives a single result
// with has_char low. A rejected or overflowed line gives no result and costs nothing
// beyond its newline transaction.
// The line memory needs no clearing: only entries written in the current line are read.

module serial_display_command_parser #(
	parameter int LINE_BYTES = sdcp_pkg::LINE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            display_row,
	output logic      [7:0] text_char,
	output logic            has_char,
	output logic            last_of_run
);

	import sdcp_pkg::*;

	localparam int AW = $clog2(LINE_BYTES);

	line_verdict_t verdict;
	logic          fire;
	logic          busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [AW-1:0] text_start;
	logic [AW-1:0] text_end;

	// Hold off input while a run goes out; the store is never written then.
	assign in_stall = busy;
	assign fire     = in_valid && !in_stall;

	sdcp_line_scan #(
		.LINE_BYTES (LINE_BYTES),
		.AW         (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (rx_byte),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.verdict    (verdict),
		.text_start (text_start),
		.text_end   (text_end)
	);

	sdcp_line_mem #(
		.DEPTH   (LINE_BYTES),
		.AW      (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sdcp_emit #(
		.AW          (AW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.verdict     (verdict),
		.text_start  (text_start),
		.text_end    (text_end),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.display_row (display_row),
		.text_char   (text_char),
		.has_char    (has_char),
		.last_of_run (last_of_run)
	);

	// Reads and writes of the store never overlap, so no forwarding is needed.
	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !out_valid && !rd_en)
		else $error("line store written while a run is going out");

	a_newline_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.emit |=> out_valid && in_stall)
		else $error("accepted line did not start a run");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_char) |-> last_of_run && text_char == CH_NUL)
		else $error("empty-text result malformed");

endmodule

`default_nettype wire
